// ===== sv/bsb_pkg.sv =====
// Shared constants and control/status types for the byte bubble sorter.
`default_nettype none

package bsb_pkg;

  localparam int MAX_ITEMS = 32;
  localparam int DATA_W    = 8;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;        // input beat accepted
    logic pass_start;   // read entry 0, index to 1
    logic load_held;    // held <= first entry of the pass
    logic cmp_step;     // compare-and-swap one adjacent pair
    logic pass_end;     // write held at top of unsorted part
    logic out_start;    // index to 0 for unloading
    logic out_capture;  // load result register from the store
    logic out_next;     // result beat taken, advance index
    logic finish;       // batch done, clear count and flag
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic limit_gt1;    // unsorted part still has a pair
    logic cmp_last;     // current compare is the last of the pass
    logic out_last;     // result register holds the final element
  } stat_t;

endpackage

`default_nettype wire

// ===== sv/bsb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== sv/bsb_dp.sv =====
// Datapath: element store, batch count, pass limit, held value and result register.
`default_nettype none

module bsb_dp (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire bsb_pkg::cmd_t             cmd,
  input  wire logic [bsb_pkg::DATA_W-1:0] value,
  input  wire logic                      last_in,
  output bsb_pkg::stat_t                 stat,
  output logic [bsb_pkg::DATA_W-1:0]     sorted_value,
  output logic                           last_out,
  output logic                           overflow
);

  logic [bsb_pkg::CNT_W-1:0]  count;
  logic                       ovf_seen;
  logic [bsb_pkg::CNT_W-1:0]  limit;
  logic [bsb_pkg::CNT_W-1:0]  idx;
  logic [bsb_pkg::DATA_W-1:0] held;

  logic                       full;
  logic [bsb_pkg::CNT_W-1:0]  count_inc;
  logic [bsb_pkg::CNT_W-1:0]  idx_m2;
  logic [bsb_pkg::CNT_W-1:0]  limit_m1;
  logic [bsb_pkg::CNT_W-1:0]  idx_p1;
  logic                       held_gt;

  logic                       wr_en;
  logic [bsb_pkg::IDX_W-1:0]  wr_addr;
  logic [bsb_pkg::DATA_W-1:0] wr_data;
  logic [bsb_pkg::IDX_W-1:0]  rd_addr;
  logic [bsb_pkg::DATA_W-1:0] rd_data;

  assign full      = (count == bsb_pkg::CNT_W'(bsb_pkg::MAX_ITEMS));
  assign count_inc = count + bsb_pkg::CNT_W'(1);
  assign idx_m2    = idx - bsb_pkg::CNT_W'(2);
  assign limit_m1  = limit - bsb_pkg::CNT_W'(1);
  assign idx_p1    = idx + bsb_pkg::CNT_W'(1);
  assign held_gt   = (held > rd_data);

  assign stat.limit_gt1 = (limit > bsb_pkg::CNT_W'(1));
  assign stat.cmp_last  = (idx == limit);
  assign stat.out_last  = (idx_p1 == count);

  // Write port: intake, pass compares (lower of the pair), pass end (held max).
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[bsb_pkg::IDX_W-1:0];
    wr_data = value;
    if (cmd.store) begin
      wr_en = !full;
    end else if (cmd.cmp_step) begin
      wr_en   = 1'b1;
      wr_addr = idx_m2[bsb_pkg::IDX_W-1:0];
      wr_data = held_gt ? rd_data : held;
    end else if (cmd.pass_end) begin
      wr_en   = 1'b1;
      wr_addr = limit_m1[bsb_pkg::IDX_W-1:0];
      wr_data = held;
    end
  end

  assign rd_addr = cmd.pass_start ? '0 : idx[bsb_pkg::IDX_W-1:0];

  bsb_ram #(
    .WIDTH (bsb_pkg::DATA_W),
    .DEPTH (bsb_pkg::MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf_seen <= 1'b0;
    end else if (cmd.finish) begin
      count    <= '0;
      ovf_seen <= 1'b0;
    end else if (cmd.store) begin
      if (full) begin
        ovf_seen <= 1'b1;
      end else begin
        count <= count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && last_in) begin
      limit <= full ? count : count_inc;
    end else if (cmd.pass_end) begin
      limit <= limit_m1;
    end

    if (cmd.pass_start) begin
      idx <= bsb_pkg::CNT_W'(1);
    end else if (cmd.load_held || cmd.cmp_step || cmd.out_next) begin
      idx <= idx_p1;
    end else if (cmd.out_start) begin
      idx <= '0;
    end

    if (cmd.load_held) begin
      held <= rd_data;
    end else if (cmd.cmp_step && !held_gt) begin
      held <= rd_data;
    end

    if (cmd.out_capture) begin
      sorted_value <= rd_data;
      last_out     <= stat.out_last;
      overflow     <= ovf_seen;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bsb_ctrl.sv =====
// Controller: sequences intake, sort passes and result unloading.
`default_nettype none

module bsb_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  input  wire logic           last_in,
  input  wire logic           result_stall,
  input  wire bsb_pkg::stat_t stat,
  output bsb_pkg::cmd_t       cmd,
  output logic                item_stall,
  output logic                result_valid
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_LOAD  = 4'd2;
  localparam logic [3:0] S_CMP   = 4'd3;
  localparam logic [3:0] S_END   = 4'd4;
  localparam logic [3:0] S_ORD   = 4'd5;
  localparam logic [3:0] S_OLD   = 4'd6;
  localparam logic [3:0] S_OWT   = 4'd7;

  logic [3:0] state;
  logic [3:0] state_next;

  assign item_stall   = (state != S_IDLE);
  assign result_valid = (state == S_OWT);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.store = 1'b1;
          if (last_in) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (stat.limit_gt1) begin
          cmd.pass_start = 1'b1;
          state_next     = S_LOAD;
        end else begin
          cmd.out_start = 1'b1;
          state_next    = S_ORD;
        end
      end
      S_LOAD: begin
        cmd.load_held = 1'b1;
        state_next    = S_CMP;
      end
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        if (stat.cmp_last) begin
          state_next = S_END;
        end
      end
      S_END: begin
        cmd.pass_end = 1'b1;
        state_next   = S_CHECK;
      end
      S_ORD: begin
        state_next = S_OLD;
      end
      S_OLD: begin
        cmd.out_capture = 1'b1;
        state_next      = S_OWT;
      end
      S_OWT: begin
        if (!result_stall) begin
          if (stat.out_last) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.out_next = 1'b1;
            state_next   = S_ORD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bubble_sort_bytes_unit.sv =====
// Top level of the byte bubble sorter: controller plus datapath.
//
//   channel   valid          stall          payload
//   -------   ------------   ------------   ------------------------------------
//   item      item_valid     item_stall     value[7:0], last_in
//   result    result_valid   result_stall   sorted_value[7:0], last_out, overflow
//
// Intake takes one beat per cycle while item_stall is low. After the beat with
// last_in set, a batch of N stored bytes is sorted by N-1 passes, each pass
// walking the unsorted part with one store read port feeding the compare; each
// result beat is read from the store, captured in the result register and held
// until taken. Bytes past 32 are dropped. item_stall is high after the final
// intake beat until the last result beat is taken. Synchronous reset clears
// count, overflow flag and controller state; the store itself is not cleared,
// as only entries of the current batch are read.
`default_nettype none

module bubble_sort_bytes_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire logic [bsb_pkg::DATA_W-1:0] value,
  input  wire logic                       last_in,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic [bsb_pkg::DATA_W-1:0]      sorted_value,
  output logic                            last_out,
  output logic                            overflow
);

  // Command and status groups between sequencer and datapath.
  bsb_pkg::cmd_t  cmd;
  bsb_pkg::stat_t stat;

  bsb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .last_in      (last_in),
    .result_stall (result_stall),
    .stat         (stat),
    .cmd          (cmd),
    .item_stall   (item_stall),
    .result_valid (result_valid)
  );

  // Store, counters and the result register live here; the result register
  // holds steady while result_valid is high and the beat is stalled.
  bsb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (value),
    .last_in      (last_in),
    .stat         (stat),
    .sorted_value (sorted_value),
    .last_out     (last_out),
    .overflow     (overflow)
  );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for bubble_sort_bytes_unit: random batches, overflow, backpressure.
`timescale 1ns / 1ps

module tb_top;

  // One result beat as the sorter should present it.
  typedef struct packed {
    logic [bsb_pkg::DATA_W-1:0] value;
    logic                       last;
    logic                       ovf;
  } sorted_beat_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       item_valid;
  logic                       item_stall;
  logic [bsb_pkg::DATA_W-1:0] value;
  logic                       last_in;
  logic                       result_valid;
  logic                       result_stall;
  logic [bsb_pkg::DATA_W-1:0] sorted_value;
  logic                       last_out;
  logic                       overflow;

  // Random gaps on both channels; cleared for the closing full-rate part.
  bit idle_on;
  // Receiver hold-off request, in cycles; taken up by the receiver process.
  int hold_request;
  int error_count;

  // Predictor state: the batch gathered so far, as the block stores it.
  logic [bsb_pkg::DATA_W-1:0] batch_bytes [bsb_pkg::MAX_ITEMS];
  int                         batch_count;
  bit                         batch_dropped;
  sorted_beat_t               pending_sorted [$];

  bubble_sort_bytes_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .value        (value),
    .last_in      (last_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sorted_value (sorted_value),
    .last_out     (last_out),
    .overflow     (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    error_count++;
  endtask

  // Track one accepted byte; on the final byte, sort the batch and queue its beats.
  task automatic collect_and_sort(input logic [bsb_pkg::DATA_W-1:0] v, input logic last);
    logic [bsb_pkg::DATA_W-1:0] t;
    if (batch_count < bsb_pkg::MAX_ITEMS) begin
      batch_bytes[batch_count] = v;
      batch_count++;
    end else begin
      // store full: byte is lost, whole batch gets flagged
      batch_dropped = 1'b1;
    end
    if (last) begin
      for (int lim = batch_count; lim > 1; lim--) begin
        for (int k = 0; k + 1 < lim; k++) begin
          if (batch_bytes[k] > batch_bytes[k+1]) begin
            t                = batch_bytes[k];
            batch_bytes[k]   = batch_bytes[k+1];
            batch_bytes[k+1] = t;
          end
        end
      end
      for (int k = 0; k < batch_count; k++)
        pending_sorted.push_back('{batch_bytes[k], k + 1 == batch_count, batch_dropped});
      batch_count   = 0;
      batch_dropped = 1'b0;
    end
  endtask

  // Offer one beat from a falling edge and hold it until taken. Valid is left
  // high on return so back-to-back beats never glitch it.
  task automatic send_byte(input logic [bsb_pkg::DATA_W-1:0] v, input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      item_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    item_valid = 1'b1;
    value      = v;
    last_in    = last;
    do @(posedge clk); while (item_stall);
    collect_and_sort(v, last);
    @(negedge clk);
  endtask

  // Bytes taken from the low end of seq first; last flag on the n-th.
  task automatic send_bytes(input logic [255:0] seq, input int n);
    for (int i = 0; i < n; i++) send_byte(seq[8*i +: 8], i == n - 1);
  endtask

  task automatic send_random_batch(input int len);
    bit narrow;
    narrow = ($urandom_range(0, 3) == 0);   // tight value range -> many duplicates
    for (int i = 0; i < len; i++)
      send_byte(bsb_pkg::DATA_W'(narrow ? $urandom_range(0, 3) : $urandom_range(0, 255)),
                i == len - 1);
  endtask

  // Single-byte batch, all-bit extremes, reversed input with duplicates,
  // already-sorted input.
  task automatic test_corner_values();
    send_bytes(8'hFF, 1);
    send_bytes({8'd170, 8'd85, 8'd127, 8'd254, 8'd1, 8'd128, 8'd255, 8'd0}, 8);
    send_bytes({8'd0, 8'd3, 8'd7, 8'd7, 8'd9}, 5);
    send_bytes({8'd3, 8'd2, 8'd1}, 3);
  endtask

  // Mostly short batches, now and then a long one up to the store size.
  task automatic test_random_batches();
    int sent;
    int r;
    int len;
    sent = 0;
    while (sent < 20) begin
      r = $urandom_range(0, 9);
      if (r < 7)      len = $urandom_range(1, 6);
      else if (r < 9) len = $urandom_range(7, 16);
      else            len = $urandom_range(24, bsb_pkg::MAX_ITEMS);
      send_random_batch(len);
      sent += len;
    end
  endtask

  // Exactly full, final byte arriving on a full store, several bytes dropped.
  task automatic test_overflow_batches();
    send_random_batch(bsb_pkg::MAX_ITEMS);
    send_random_batch(bsb_pkg::MAX_ITEMS + 1);
    send_random_batch(bsb_pkg::MAX_ITEMS + 3);
  endtask

  // Receiver goes quiet for a long stretch; the next batch piles up at the input.
  task automatic test_backpressure();
    hold_request = 400;
    send_random_batch(12);
    send_random_batch(5);
  endtask

  // No gaps on either side for the closing batches.
  task automatic test_full_rate();
    idle_on = 1'b0;
    repeat (3) send_random_batch($urandom_range(2, 6));
  endtask

  // Result side: random stall bursts, plus the long hold-off when asked.
  initial begin
    int stall_left;
    stall_left   = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        stall_left   = hold_request;
        hold_request = 0;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16);
      end
      if (stall_left > 0) begin
        result_stall = 1'b1;
        stall_left--;
      end else begin
        result_stall = 1'b0;
      end
    end
  end

  // Compare every taken result beat against the oldest expectation.
  always @(posedge clk) begin : check_beat
    sorted_beat_t want;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (pending_sorted.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with nothing expected", sorted_value));
      end else begin
        want = pending_sorted.pop_front();
        if (sorted_value !== want.value)
          report_mismatch($sformatf("sorted_value %0d, want %0d", sorted_value, want.value));
        if (last_out !== want.last)
          report_mismatch($sformatf("last_out %b, want %b", last_out, want.last));
        if (overflow !== want.ovf)
          report_mismatch($sformatf("overflow %b, want %b", overflow, want.ovf));
      end
    end
  end

  initial begin
    int guard;
    rst           = 1'b1;
    item_valid    = 1'b0;
    value         = '0;
    last_in       = 1'b0;
    idle_on       = 1'b0;
    hold_request  = 0;
    error_count   = 0;
    batch_count   = 0;
    batch_dropped = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst     = 1'b0;
    idle_on = 1'b1;

    test_corner_values();
    test_random_batches();
    test_overflow_batches();
    test_backpressure();
    test_full_rate();
    item_valid = 1'b0;

    // Drain: wait until every expected result beat has arrived, within a guard.
    guard = 0;
    while (pending_sorted.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (pending_sorted.size() != 0)
      report_mismatch($sformatf("%0d result beats never arrived", pending_sorted.size()));

    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
